FILE: rtl/core/qve_pkg.sv
// ----------------------------------------------------------------------------
// qve_pkg
// Types and constants shared by the query value extractor modules.
// ----------------------------------------------------------------------------
package qve_pkg;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned KEY_LEN_W  = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_BYTES  = 2'd0,
    REG_KEY_LENGTH = 2'd1
  } cfg_reg_e;

  // value terminators
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [1:0] {
    OUT_CONTINUE  = 2'd0,
    OUT_FOUND     = 2'd1,
    OUT_NOT_FOUND = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    PH_SEARCH = 3'b001,
    PH_VALUE  = 3'b010,
    PH_DONE   = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       has_byte;
    outcome_e   outcome;
    logic       last;
  } out_item_t;

  // window control from the phase logic
  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  function automatic logic is_terminator(input logic [7:0] b);
    return (b == CH_AMP) || (b == CH_SPACE) || (b == CH_CR) ||
           (b == CH_LF) || (b == CH_NUL);
  endfunction

endpackage

FILE: rtl/core/qve_match.sv
// ----------------------------------------------------------------------------
// qve_match
// Key registers, sliding byte window and parallel key compare.
// ----------------------------------------------------------------------------
module qve_match #(
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [qve_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [qve_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  qve_pkg::win_ctl_t                ctl_i,
  input  logic [7:0]                       text_byte_i,
  output logic                             match_o
);
  import qve_pkg::*;

  localparam int unsigned LEN_W = $clog2(KEY_BYTES + 1);

  logic [KEY_BYTES-1:0][7:0] key_q;
  logic [KEY_LEN_W-1:0]      klen_q;
  logic [KEY_BYTES-1:0][7:0] win_q, win_d, win_new;
  logic [LEN_W-1:0]          fill_q, fill_d, fill_new;
  logic [LEN_W-1:0]          eff_len;
  logic [KEY_BYTES-1:0]      len_match;
  logic                      sel_match;

  // config writes; indexes outside the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      klen_q <= KEY_LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_KEY_BYTES:  key_q  <= cfg_data_i[8*KEY_BYTES-1:0];
        REG_KEY_LENGTH: klen_q <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (klen_q == '0) begin
      eff_len = LEN_W'(1);
    end else if (klen_q > KEY_LEN_W'(KEY_BYTES)) begin
      eff_len = LEN_W'(KEY_BYTES);
    end else begin
      eff_len = LEN_W'(klen_q);
    end
  end

  // newest byte in lane 0
  always_comb begin
    win_new[0] = text_byte_i;
    for (int i = 1; i < KEY_BYTES; i++) begin
      win_new[i] = win_q[i-1];
    end
    fill_new = (fill_q == LEN_W'(KEY_BYTES)) ? fill_q : fill_q + LEN_W'(1);
  end

  // one compare per candidate length m+1: key byte k against window lane m-k
  always_comb begin
    for (int m = 0; m < KEY_BYTES; m++) begin
      len_match[m] = 1'b1;
      for (int k = 0; k < KEY_BYTES; k++) begin
        if (k <= m) begin
          if (key_q[k] != win_new[m-k]) len_match[m] = 1'b0;
        end
      end
    end
    sel_match = 1'b0;
    for (int m = 0; m < KEY_BYTES; m++) begin
      if (eff_len == LEN_W'(m + 1)) sel_match = len_match[m];
    end
  end

  assign match_o = sel_match && (fill_new >= eff_len);

  always_comb begin
    win_d  = win_q;
    fill_d = fill_q;
    if (ctl_i.clear) begin
      win_d  = '0;
      fill_d = '0;
    end else if (ctl_i.shift) begin
      win_d  = win_new;
      fill_d = fill_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      fill_q <= fill_d;
    end
  end

endmodule

FILE: rtl/core/qve_phase.sv
// ----------------------------------------------------------------------------
// qve_phase
// Search / value / done sequencing and result formation per request.
// ----------------------------------------------------------------------------
module qve_phase (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  qve_pkg::in_item_t   in_data_i,
  input  logic                match_i,
  output qve_pkg::win_ctl_t   ctl_o,
  output logic                res_valid_o,
  output qve_pkg::out_item_t  res_o
);
  import qve_pkg::*;

  phase_e    phase_q, phase_d, phase_nx;
  logic      res_v;
  logic [7:0] b;
  logic       eot;

  assign b   = in_data_i.text_byte;
  assign eot = in_data_i.end_of_text;

  always_comb begin
    phase_nx         = phase_q;
    res_v            = 1'b0;
    res_o.value_byte = '0;
    res_o.has_byte   = 1'b0;
    res_o.outcome    = OUT_FOUND;
    res_o.last       = eot;
    unique case (phase_q)
      PH_SEARCH: begin
        if (match_i) phase_nx = PH_VALUE;
        res_v         = eot;
        res_o.outcome = match_i ? OUT_FOUND : OUT_NOT_FOUND;
      end
      PH_VALUE: begin
        if (is_terminator(b)) begin
          phase_nx = PH_DONE;
          res_v    = eot;
        end else begin
          res_v            = 1'b1;
          res_o.value_byte = b;
          res_o.has_byte   = 1'b1;
          res_o.outcome    = eot ? OUT_FOUND : OUT_CONTINUE;
        end
      end
      default: begin
        res_v = eot;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (accept_i) phase_d = eot ? PH_SEARCH : phase_nx;
  end

  assign ctl_o.shift = accept_i && (phase_q == PH_SEARCH);
  assign ctl_o.clear = accept_i && eot;
  assign res_valid_o = accept_i && res_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

FILE: rtl/core/qve_out_skid.sv
// ----------------------------------------------------------------------------
// qve_out_skid
// Result register with one skid entry behind it.
// ----------------------------------------------------------------------------
module qve_out_skid (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  qve_pkg::out_item_t  data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output qve_pkg::out_item_t  out_data_o
);
  import qve_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_item_t out_data_q, out_data_d;
  out_item_t skid_data_q, skid_data_d;
  logic      pop;

  assign pop = out_valid_q && !out_stall_i;

  // push only arrives while the skid entry is empty
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_data_d  = data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d  = data_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: rtl/core/query_value_extractor_core.sv
// ----------------------------------------------------------------------------
// query_value_extractor_core
// Finds a configured key in a byte stream and streams out the value after it.
//
//   channel | signals                           | direction
//   --------+-----------------------------------+----------
//   in      | in_valid_i, in_stall_o, in_data_i | request in
//   out     | out_valid_o, out_stall_i, out_data_o | result out
//   cfg     | cfg_we_i, cfg_idx_i, cfg_data_i   | register write
//
// One byte per cycle while in_stall_o is low; results are registered.
// The window compare and phase update sit in front of the result register.
// Reset clears window, phase and output buffer; key = 0, key length = 1.
// Output stalls fill a result register plus one skid entry; in_stall_o
// rises only when both hold results.
// ----------------------------------------------------------------------------
module query_value_extractor_core #(
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [qve_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [qve_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  qve_pkg::in_item_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output qve_pkg::out_item_t             out_data_o
);
  import qve_pkg::*;

  logic      accept;
  logic      match;
  logic      res_valid;
  logic      full;
  win_ctl_t  win_ctl;
  out_item_t res;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  qve_match #(
    .KEY_BYTES(KEY_BYTES)
  ) u_match (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .ctl_i      (win_ctl),
    .text_byte_i(in_data_i.text_byte),
    .match_o    (match)
  );

  qve_phase u_phase (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .match_i    (match),
    .ctl_o      (win_ctl),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  qve_out_skid u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (res_valid),
    .data_i     (res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: rtl/core/qve_checker.sv
// ----------------------------------------------------------------------------
// qve_checker
// Port-level checks for the query value extractor, bound to the top level.
// ----------------------------------------------------------------------------
module qve_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input qve_pkg::out_item_t  out_data_o
);
  import qve_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // no value byte without has_byte
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.has_byte |-> out_data_o.value_byte == 8'h00)
    else $error("value byte set without has_byte");

  // not found only at end of text, with no value byte
  a_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.outcome == OUT_NOT_FOUND
      |-> out_data_o.last && !out_data_o.has_byte)
    else $error("not-found result malformed");

  // any result before the end of text is a value character
  a_mid_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last
      |-> out_data_o.has_byte && out_data_o.outcome == OUT_CONTINUE)
    else $error("mid-text result is not a value character");

endmodule

bind query_value_extractor_core qve_checker u_qve_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
